/* sv/touchpad_dpad_key_edge_events_defines.svh */
// Assertion macros shared by the touchpad d-pad key edge event checkers.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef TOUCHPAD_DPAD_KEY_EDGE_EVENTS_DEFINES_SVH
`define TOUCHPAD_DPAD_KEY_EDGE_EVENTS_DEFINES_SVH

// Check a property on the rising clock, muted while reset is asserted.
`define TDKE_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tdke assertion failed");

// Check a property on the rising clock, also during reset.
`define TDKE_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("tdke assertion failed");

`endif

/* sv/tdke_pkg.sv */
// Package for the touchpad d-pad key edge event block: payload types,
// register indexes, key numbering and geometry constants. No dependencies.
package tdke_pkg;

    localparam int NumKeys     = 11;
    localparam int NumButtons  = 6;
    localparam int QueueDepth  = 2;
    localparam int CfgIndexW   = 8;
    localparam int CfgDataW    = 8;

    localparam logic [10:0] TouchCenter = 11'sd157;
    localparam logic [10:0] ZoneLimit   = 11'sd52;
    localparam logic [7:0]  XlowMask    = 8'hFC;

    localparam logic [CfgIndexW-1:0] RegKeysEnabled = CfgIndexW'(0);
    localparam logic [CfgIndexW-1:0] RegDpadMode    = CfgIndexW'(1);

    localparam int KeyClick  = 3;
    localparam int KeyCenter = 6;
    localparam int KeyUp     = 7;
    localparam int KeyDown   = 8;
    localparam int KeyRight  = 9;
    localparam int KeyLeft   = 10;

    localparam logic [NumKeys-1:0] ScanMaskNormal = 11'b000_0011_1111;
    localparam logic [NumKeys-1:0] ScanMaskDpad   = 11'b111_1111_0111;

    typedef struct packed {
        logic [7:0] touch_byte_a;
        logic [7:0] touch_byte_b;
        logic [7:0] touch_byte_c;
        logic [7:0] button_byte;
    } t_in;

    typedef struct packed {
        logic [3:0] key_index;
        logic       pressed;
        logic       last_event;
    } t_out;

    typedef struct packed {
        logic keys_enabled;
        logic zone_scan;
    } t_cfg;

    // One report's work for the scanner: which keys changed, and their new states.
    typedef struct packed {
        logic [NumKeys-1:0] edge_mask;
        logic [NumKeys-1:0] key_states;
    } t_work;

endpackage

/* sv/tdke_front.sv */
// Front end: unpacks a report, sorts the touch point into d-pad zones,
// compares with the stored key states and queues the edge mask. Uses tdke_pkg.
module tdke_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tdke_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    output logic            o_ready,
    input  tdke_pkg::t_in   i_data,
    input  logic            i_queue_full,
    output logic            o_push,
    output tdke_pkg::t_work o_work
);
    import tdke_pkg::*;

    logic [NumKeys-1:0] r_prev;
    logic [NumKeys-1:0] n_prev;
    logic [9:0]         x;
    logic [9:0]         y;
    logic signed [10:0] dx;
    logic signed [10:0] dy;
    logic signed [11:0] s;
    logic signed [11:0] t;
    logic               center;
    logic               click;
    logic               s_pos, s_neg, t_pos, t_neg;
    logic [NumKeys-1:0] keys;
    logic [NumKeys-1:0] scan;
    logic [NumKeys-1:0] edges;
    logic               accept;

    function automatic logic in_zone(input logic signed [10:0] d);
        in_zone = (d > -$signed(ZoneLimit)) && (d < $signed(ZoneLimit)) && (d != '0);
    endfunction

    always_comb begin
        x  = {i_data.touch_byte_a[3:0], 6'((i_data.touch_byte_b & XlowMask) >> 2)};
        y  = {i_data.touch_byte_b[1:0], i_data.touch_byte_c};
        dx = (x == '0) ? '0 : $signed({1'b0, x}) - $signed(TouchCenter);
        dy = (y == '0) ? '0 : $signed(TouchCenter) - $signed({1'b0, y});
        s  = 12'(dx) + 12'(dy);
        t  = 12'(dy) - 12'(dx);
        s_pos = (s >= 12'sd2);
        s_neg = (s <= -12'sd2);
        t_pos = (t >= 12'sd2);
        t_neg = (t <= -12'sd2);
        center = in_zone(dx) && in_zone(dy);
        click  = i_data.button_byte[KeyClick];

        keys = {5'b0, i_data.button_byte[NumButtons-1:0]};
        keys[KeyCenter] = click && center;
        keys[KeyUp]     = click && s_pos && t_pos && !center;
        keys[KeyDown]   = click && s_neg && t_neg && !center;
        keys[KeyRight]  = click && s_pos && t_neg && !center;
        keys[KeyLeft]   = click && s_neg && t_pos && !center;
        // Button 0 yields to the touch click, and the center zone to button 0.
        keys[0]         = keys[0] && !keys[KeyClick];
        keys[KeyClick]  = keys[KeyClick] && !keys[0];
        keys[KeyCenter] = keys[KeyCenter] && !keys[0];

        scan  = i_cfg.zone_scan ? ScanMaskDpad : ScanMaskNormal;
        edges = (keys ^ r_prev) & scan;
    end

    assign o_ready = !i_queue_full;
    assign accept  = i_valid && o_ready && i_cfg.keys_enabled;
    assign o_push  = accept && (edges != '0);
    assign o_work  = '{edge_mask: edges, key_states: keys};
    assign n_prev  = accept ? keys : r_prev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else begin
            r_prev <= n_prev;
        end
    end

endmodule

/* sv/tdke_fifo.sv */
// Short work queue between the front end and the event scanner.
// Uses tdke_pkg for the entry type.
module tdke_fifo #(
    parameter int Depth = tdke_pkg::QueueDepth
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tdke_pkg::t_work i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output tdke_pkg::t_work o_data
);
    import tdke_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    t_work            r_mem [Depth];
    logic [PtrW-1:0]  r_wr, n_wr;
    logic [PtrW-1:0]  r_rd, n_rd;
    logic [CntW-1:0]  r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CntW'(Depth));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PtrW'(Depth - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PtrW'(Depth - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

/* sv/tdke_back.sv */
// Event scanner: walks a queued edge mask, lowest key first, and emits
// one event per unstalled cycle via an output register. Uses tdke_pkg.
module tdke_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_work_valid,
    input  tdke_pkg::t_work i_work,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output tdke_pkg::t_out  o_data
);
    import tdke_pkg::*;

    logic [NumKeys-1:0] r_mask, n_mask;
    logic [NumKeys-1:0] r_states, n_states;
    logic               r_out_valid;
    t_out               r_out;
    logic [NumKeys-1:0] lowest;
    logic [NumKeys-1:0] rest;
    logic [3:0]         idx;
    logic               active;
    logic               emit;

    always_comb begin
        lowest = r_mask & (~r_mask + 1'b1);
        rest   = r_mask & ~lowest;
        idx    = '0;
        for (int i = NumKeys - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                idx = 4'(i);
            end
        end
    end

    assign active = (r_mask != '0);
    assign emit   = active && (!r_out_valid || i_ready);
    assign o_pop  = i_work_valid && (!active || (emit && rest == '0));

    always_comb begin
        n_mask   = r_mask;
        n_states = r_states;
        if (o_pop) begin
            n_mask   = i_work.edge_mask;
            n_states = i_work.key_states;
        end else if (emit) begin
            n_mask = rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mask <= n_mask;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_states <= n_states;
        if (emit) begin
            r_out <= '{key_index: idx, pressed: r_states[idx], last_event: (rest == '0)};
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

/* sv/touchpad_dpad_key_edge_events.sv */
// Touchpad d-pad key edge events. Each accepted report yields zero to ten
// events, one per key that changed state, lowest key first, with last_event
// set on the final one. The front end takes a report in any cycle in which
// its two-entry work queue has room and classifies it in that same cycle;
// the scanner then emits one event per cycle while the receiver is ready,
// loading each queued report into its mask register and each event into
// the output register. A report with no edges takes no queue slot. Set the
// two registers only while the block is idle; reads of them are not
// supported. Depends on tdke_pkg, tdke_front, tdke_fifo and tdke_back.
module touchpad_dpad_key_edge_events #(
    parameter int QueueDepth = tdke_pkg::QueueDepth
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // report input channel
    input  logic                            i_valid,
    output logic                            o_ready,
    input  tdke_pkg::t_in                   i_data,
    // event output channel
    output logic                            o_valid,
    input  logic                            i_ready,
    output tdke_pkg::t_out                  o_data,
    // register write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tdke_pkg::CfgIndexW-1:0]  i_cfg_index,
    input  logic [tdke_pkg::CfgDataW-1:0]   i_cfg_data
);
    import tdke_pkg::*;

    t_cfg  r_cfg;
    t_work push_work;
    t_work head_work;
    logic  push;
    logic  queue_full;
    logic  head_valid;
    logic  pop;

    // Register writes are always taken; unknown indexes are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                RegKeysEnabled: r_cfg.keys_enabled <= i_cfg_data[0];
                RegDpadMode:    r_cfg.zone_scan    <= i_cfg_data[0];
                default:        ;
            endcase
        end
    end

    // Classify the report and track the stored key states.
    tdke_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data       (i_data),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_work       (push_work)
    );

    // Decouple classification from event emission.
    tdke_fifo #(
        .Depth (QueueDepth)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_work),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_data  (head_work)
    );

    // Emit one event per unstalled cycle from the head of the queue.
    tdke_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work_valid (head_valid),
        .i_work       (head_work),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_data       (o_data)
    );

endmodule

/* sv/tdke_checker.sv */
// Port-level checks for touchpad_dpad_key_edge_events, bound to the top level.
// Depends on tdke_pkg and the assertion macro header.
`include "touchpad_dpad_key_edge_events_defines.svh"

module tdke_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_valid,
    input logic           i_ready,
    input tdke_pkg::t_out o_data,
    input logic           o_cfg_ready
);
    import tdke_pkg::*;

    // A stalled event holds.
    `TDKE_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_data))
    // Only real key numbers come out.
    `TDKE_ASSERT(a_key_range, i_clk, i_rst_n, o_valid |-> o_data.key_index <= 4'(KeyLeft))
    // Reset empties the output stage.
    `TDKE_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid)
    // Register writes never stall.
    `TDKE_ASSERT(a_cfg_ready, i_clk, i_rst_n, o_cfg_ready)

endmodule

bind touchpad_dpad_key_edge_events tdke_checker u_tdke_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_data      (o_data),
    .o_cfg_ready (o_cfg_ready)
);

/* bench/tdke_event_checker.sv */
`timescale 1ns / 100ps
// Event scoreboard for the touchpad d-pad key edge event block: watches the
// report, event and register channels, predicts the events and compares them.
// Depends on tdke_pkg only.
module tdke_event_checker
    import tdke_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  t_in                  i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  t_out                 i_out_data,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CfgIndexW-1:0] i_cfg_index,
    input  logic [CfgDataW-1:0]  i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam int ReportLimit = 10;

    logic               keys_en     = 1'b0;
    logic               dpad_on     = 1'b0;
    logic [NumKeys-1:0] stored_keys = '0;
    t_out               expected_events[$];
    int                 fails       = 0;

    function automatic bit in_zone(int d);
        return d > -int'(ZoneLimit) && d < int'(ZoneLimit) && d != 0;
    endfunction

    // Only the sign of the 45 degree rotation matters; truncation zeroes +-1.
    function automatic int rot_sign(int sum);
        if (sum >= 2) return 1;
        if (sum <= -2) return -1;
        return 0;
    endfunction

    // Key states of one report before the button combination rule.
    function automatic logic [NumKeys-1:0] raw_keys(t_in r);
        logic [9:0]         x;
        logic [9:0]         y;
        int                 dx;
        int                 dy;
        int                 sx;
        int                 ty;
        bit                 center;
        bit                 click;
        logic [NumKeys-1:0] k;
        x      = {r.touch_byte_a[3:0], r.touch_byte_b[7:2]};
        y      = {r.touch_byte_b[1:0], r.touch_byte_c};
        dx     = (x == 0) ? 0 : int'(x) - int'(TouchCenter);
        dy     = (y == 0) ? 0 : int'(TouchCenter) - int'(y);
        center = in_zone(dx) && in_zone(dy);
        sx     = rot_sign(dx + dy);
        ty     = rot_sign(dy - dx);
        click  = r.button_byte[KeyClick];
        k      = '0;
        k[NumButtons-1:0] = r.button_byte[NumButtons-1:0];
        k[KeyCenter] = click && center;
        k[KeyUp]     = click && sx > 0 && ty > 0 && !center;
        k[KeyDown]   = click && sx < 0 && ty < 0 && !center;
        k[KeyRight]  = click && sx > 0 && ty < 0 && !center;
        k[KeyLeft]   = click && sx < 0 && ty > 0 && !center;
        return k;
    endfunction

    task automatic predict_events(input t_in r);
        logic [NumKeys-1:0] k;
        t_out               evs[NumKeys];
        int                 n;
        int                 limit;
        k = raw_keys(r);
        n = 0;
        if (!keys_en) return;
        k[0]         = k[0] && !k[KeyClick];
        k[KeyClick]  = k[KeyClick] && !k[0];
        k[KeyCenter] = k[KeyCenter] && !k[0];
        limit = dpad_on ? NumKeys : NumButtons;
        for (int i = 0; i < limit; i++) begin
            if (dpad_on && i == KeyClick) continue;
            if (k[i] != stored_keys[i]) begin
                evs[n].key_index  = 4'(i);
                evs[n].pressed    = k[i];
                evs[n].last_event = 1'b0;
                n++;
            end
        end
        if (n > 0) evs[n-1].last_event = 1'b1;
        for (int i = 0; i < n; i++) expected_events.push_back(evs[i]);
        stored_keys = k;
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            keys_en     = 1'b0;
            dpad_on     = 1'b0;
            stored_keys = '0;
            expected_events.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == RegKeysEnabled) keys_en = i_cfg_data[0];
                else if (i_cfg_index == RegDpadMode) dpad_on = i_cfg_data[0];
            end
            if (i_in_valid && i_in_ready) predict_events(i_in_data);
            if (i_out_valid && i_out_ready) begin
                if (expected_events.size() == 0) begin
                    fails++;
                    if (fails <= ReportLimit)
                        $display("%0t: unexpected event key %0d pressed %0b last %0b",
                                 $realtime, i_out_data.key_index, i_out_data.pressed,
                                 i_out_data.last_event);
                end else begin
                    want = expected_events.pop_front();
                    if (i_out_data.key_index !== want.key_index ||
                        i_out_data.pressed !== want.pressed ||
                        i_out_data.last_event !== want.last_event) begin
                        fails++;
                        // fields shown as key/pressed/last
                        if (fails <= ReportLimit)
                            $display("%0t: event mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                                     $realtime, want.key_index, want.pressed,
                                     want.last_event, i_out_data.key_index,
                                     i_out_data.pressed, i_out_data.last_event);
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_events.size();
    end

endmodule

/* bench/tb_touchpad_dpad_key_edge_events.sv */
`timescale 1ns / 100ps
// Top of the touchpad d-pad key edge event bench: clock, reset, report and
// register stimulus, receiver stalls, watchdog and verdict.
// Depends on tdke_pkg, tdke_event_checker and the block itself.
module tb_touchpad_dpad_key_edge_events;
    import tdke_pkg::*;

    localparam int ResetCycles = 11;
    // Settling margin after the last predicted event.
    localparam int DrainCycles = 16;
    localparam int HoldCycles  = 300;
    localparam int IdleLimit   = 4000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    t_in                  i_data;
    logic                 o_valid;
    logic                 i_ready;
    t_out                 o_data;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CfgIndexW-1:0] i_cfg_index;
    logic [CfgDataW-1:0]  i_cfg_data;

    int fail_count;
    int pending_events;
    int idle_cycles = 0;
    int burst_left  = 0;
    // Long receiver hold-off: requested here, carried out by the sink process.
    bit hold_req    = 1'b0;
    bit hold_served = 1'b0;

    touchpad_dpad_key_edge_events u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    tdke_event_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_data    (i_data),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_data   (o_data),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_events)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Pack a touch point and button byte into a report; the unused high
    // nibble of the first byte gets random content so its bits toggle too.
    function automatic t_in make_report(logic [9:0] x, logic [9:0] y, logic [7:0] buttons);
        t_in r;
        r.touch_byte_a = {4'($urandom), x[9:6]};
        r.touch_byte_b = {x[5:0], y[9:8]};
        r.touch_byte_c = y[7:0];
        r.button_byte  = buttons;
        return r;
    endfunction

    // Mostly clicked touches aimed at the zone borders and diagonals, some
    // zero coordinates, and some fully random report bytes as noise.
    function automatic t_in random_report();
        int         kind;
        int         cx;
        int         cy;
        int         d;
        int         e;
        logic [7:0] buttons;
        kind    = $urandom_range(0, 9);
        buttons = 8'($urandom);
        if ($urandom_range(0, 9) < 7) buttons[KeyClick] = 1'b1;
        d = int'($urandom_range(0, 200)) - 100;
        e = int'($urandom_range(0, 4)) - 2;
        case (kind) inside
            [0:2]: begin
                cx = 157 + int'($urandom_range(0, 120)) - 60;
                cy = 157 + int'($urandom_range(0, 120)) - 60;
            end
            [3:4]: begin
                cx = 157 + ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(49, 55));
                cy = 157 + int'($urandom_range(0, 120)) - 60;
                if ($urandom_range(0, 1)) begin
                    d  = cx;
                    cx = cy;
                    cy = d;
                end
            end
            [5:6]: begin
                cx = $urandom_range(0, 420);
                cy = $urandom_range(0, 420);
            end
            7: begin
                // straddle one of the two diagonals
                cx = 157 + d;
                cy = $urandom_range(0, 1) ? 157 - d + e : 157 + d + e;
            end
            8: begin
                cx = $urandom_range(0, 1) ? 0 : $urandom_range(100, 220);
                cy = (cx == 0) ? $urandom_range(0, 300) : 0;
            end
            default: return t_in'($urandom);
        endcase
        return make_report(10'(cx), 10'(cy), buttons);
    endfunction

    // Hold valid and payload until the transaction completes.
    task automatic send_report(input t_in r);
        i_valid <= 1'b1;
        i_data  <= r;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Send in bursts of random length, with random gaps between bursts.
    task automatic offer(input t_in r);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 30)
                                                     : $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        send_report(r);
    endtask

    // Drop valid, wait for every predicted event, then let the scanner settle
    // in case the last reports caused no events.
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_events != 0);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    // Write both registers back to back, then one unused index that must be
    // ignored. Upper data bits are random; only bit 0 counts.
    task automatic set_config(input logic ke, input logic dm);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= RegKeysEnabled;
        i_cfg_data  <= {7'($urandom), ke};
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= RegDpadMode;
        i_cfg_data  <= {7'($urandom), dm};
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CfgIndexW'($urandom_range(2, 255));
        i_cfg_data  <= CfgDataW'($urandom);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_directed();
        drain();
        set_config(1'b1, 1'b1);
        offer(make_report(10'd0, 10'd0, 8'h00));
        // click with both coordinates zero: no zone at all
        offer(make_report(10'd0, 10'd0, 8'h08));
        offer(make_report(10'd167, 10'd147, 8'h08));    // center
        offer(make_report(10'd157, 10'd50, 8'h08));     // up
        offer(make_report(10'd157, 10'd300, 8'h08));    // down
        offer(make_report(10'd300, 10'd157, 8'h08));    // right
        offer(make_report(10'd20, 10'd157, 8'h08));     // left
        offer(make_report(10'd257, 10'd57, 8'h08));     // on the diagonal
        offer(make_report(10'd257, 10'd56, 8'h08));     // one step off it
        // dx zero, both sums exactly two: smallest up
        offer(make_report(10'd157, 10'd155, 8'h08));
        offer(make_report(10'd208, 10'd106, 8'h08));    // center corner
        offer(make_report(10'd209, 10'd106, 8'h08));    // just outside center
        // button 0 with the click: click wins, center still allowed
        offer(make_report(10'd106, 10'd208, 8'h09));
        offer(make_report(10'd1023, 10'd1023, 8'hFF));
        offer(make_report(10'd167, 10'd147, 8'h3F));
        offer(make_report(10'd0, 10'd0, 8'hC0));        // ignored bits only

        // zone keys are stored without events in normal mode
        drain();
        set_config(1'b1, 1'b0);
        offer(make_report(10'd157, 10'd50, 8'h2A));
        offer(make_report(10'd20, 10'd157, 8'h15));
        offer(make_report(10'd20, 10'd157, 8'h08));

        // disabled: no events, stored states kept
        drain();
        set_config(1'b0, 1'b0);
        offer(make_report(10'd167, 10'd147, 8'h3F));
        offer(make_report(10'd0, 10'd0, 8'h00));

        // left was stored while unscanned, so only its release shows here
        drain();
        set_config(1'b1, 1'b1);
        offer(make_report(10'd20, 10'd157, 8'h08));
        offer(make_report(10'd0, 10'd0, 8'h00));
    endtask

    // One random phase. Normal phases pause halfway until every event is in;
    // the pressure phase stalls the receiver and sends back to back.
    task automatic run_phase(input logic ke, input logic dm, input int count,
                             input bit pressure);
        drain();
        set_config(ke, dm);
        if (pressure) hold_req = 1'b1;
        for (int n = 0; n < count; n++) begin
            if (pressure) begin
                send_report(random_report());
            end else begin
                if (n == count / 2) drain();
                offer(random_report());
            end
        end
    endtask

    // Receiver: segments of always-ready, coin-flip, mostly-stalled and
    // periodic ready, plus the one long hold-off on request.
    initial begin : sink
        int mode;
        int run_len;
        int period;
        bit rdy;
        forever begin
            mode    = $urandom_range(0, 3);
            run_len = $urandom_range(4, 40);
            period  = $urandom_range(2, 6);
            for (int c = 0; c < run_len; c++) begin
                @(posedge i_clk);
                if (hold_req && !hold_served) begin
                    hold_served = 1'b1;
                    i_ready <= 1'b0;
                    repeat (HoldCycles) @(posedge i_clk);
                end else begin
                    case (mode)
                        0:       rdy = 1'b1;
                        1:       rdy = $urandom_range(0, 1);
                        2:       rdy = ($urandom_range(0, 3) == 0);
                        default: rdy = (c % period == 0);
                    endcase
                    i_ready <= rdy;
                end
            end
        end
    end

    // Watchdog: end the run if no transaction completes on any channel
    // for too long.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IdleLimit) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data      = '0;
        i_ready     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (ResetCycles) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        run_phase(1'b1, 1'b1, 40, 1'b0);
        run_phase(1'b1, 1'b0, 25, 1'b0);
        run_phase(1'b0, 1'b1, 10, 1'b0);
        run_phase(1'b1, 1'b1, 35, 1'b1);
        run_phase(1'b1, 1'b0, 20, 1'b0);
        run_phase(1'b0, 1'b0, 6, 1'b0);
        run_phase(1'b1, 1'b1, 21, 1'b0);

        // drop valid, wait out every expected event and a settling margin
        drain();
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/tdke_pkg.sv
sv/tdke_front.sv
sv/tdke_fifo.sv
sv/tdke_back.sv
sv/touchpad_dpad_key_edge_events.sv
sv/tdke_checker.sv
bench/tdke_event_checker.sv
bench/tb_touchpad_dpad_key_edge_events.sv
